// ----- sv/headway_gap_grouping_core_macros.svh -----
// Assertion macros used by the checker file of the headway gap grouping core.
`ifndef HEADWAY_GAP_GROUPING_CORE_MACROS_SVH
`define HEADWAY_GAP_GROUPING_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while arst_n is low.
`define HGG_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off while arst_n is low.
`define HGG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/hgg_pkg.sv -----
// Shared types and constants of the headway gap grouping core.
package hgg_pkg;

	localparam int IN_TIME_W = 32;
	localparam int LIMIT_W   = 6;
	localparam int INIT_W    = 32;
	localparam int STEP_W    = 16;
	localparam int IDX_OUT_W = 6;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;
	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 4;

	localparam logic [1:0] REG_LIMIT = 2'd0;
	localparam logic [1:0] REG_INIT  = 2'd1;
	localparam logic [1:0] REG_STEP  = 2'd2;

	localparam logic [LIMIT_W-1:0] LIMIT_RST = 6'd35;
	localparam logic [INIT_W-1:0]  INIT_RST  = 32'd256;
	localparam logic [STEP_W-1:0]  STEP_RST  = 16'd128;

	typedef enum logic {
		OP_LOAD,
		OP_CLOSE
	} op_t;

	typedef struct packed {
		logic [IN_TIME_W-1:0] arrival;
		op_t                  op;
	} cmd_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] limit;
		logic [INIT_W-1:0]  init;
		logic [STEP_W-1:0]  step;
	} cfg_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] start;
		logic [IDX_OUT_W-1:0] stop;
		logic                 last;
	} res_t;

endpackage

// ----- sv/headway_gap_grouping_core.sv -----
// Top level of the headway gap grouping core: configuration registers and block wiring.
//
// Arrival times are taken one request per cycle, unless the queue is full, into a
// four-entry queue and then written into a single-port time store of MAX_VEHICLES
// entries. The request that carries final_vehicle starts a run over the stored set:
// one gap-counting pass at the initial threshold, and, when that leaves more than
// group_limit groups, a binary search over the number of threshold steps that takes
// TIME_BITS further passes, followed by one output pass. Each pass reads the stored
// times one at a time through the store's single read port, alternating a read and
// an evaluate state; a set of fewer than three times skips the reads, and the output
// pass waits while the result queue is full. New arrival times wait in the input
// queue during a run; the groups leave through a four-entry result queue, first the
// pair (0,0), then each group's first and last index, the final pair marked by
// last_group.
module headway_gap_grouping_core #(
	parameter int MAX_VEHICLES = 64,
	parameter int TIME_BITS    = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [hgg_pkg::IN_TIME_W-1:0]      arrival_time,
	input  logic                               final_vehicle,
	output logic                               empty,
	input  logic                               pop,
	output logic [hgg_pkg::IDX_OUT_W-1:0]      group_start,
	output logic [hgg_pkg::IDX_OUT_W-1:0]      group_end,
	output logic                               last_group,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [hgg_pkg::ADDR_W-1:0]         paddr,
	input  logic [hgg_pkg::DATA_W-1:0]         pwdata,
	output logic [hgg_pkg::DATA_W-1:0]         prdata,
	output logic                               pready
);
	import hgg_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	logic [INIT_W-1:0]  init_q;
	logic [STEP_W-1:0]  step_q;
	logic               cfg_wr;
	cfg_t               cfg;
	cmd_t               cmd;
	logic               cmd_valid;
	logic               cmd_take;
	res_t               res;
	logic               res_push;
	logic               res_full;
	res_t               res_head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
			init_q  <= INIT_RST;
			step_q  <= STEP_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_LIMIT: limit_q <= pwdata[LIMIT_W-1:0];
				REG_INIT:  init_q  <= pwdata[INIT_W-1:0];
				REG_STEP:  step_q  <= pwdata[STEP_W-1:0];
				default: begin
					limit_q <= limit_q;
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_LIMIT: prdata = DATA_W'(limit_q);
			REG_INIT:  prdata = DATA_W'(init_q);
			REG_STEP:  prdata = DATA_W'(step_q);
			default:   prdata = '0;
		endcase
	end

	always_comb begin
		cfg.limit = limit_q;
		cfg.init  = init_q;
		cfg.step  = step_q;
	end

	hgg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.arrival_time (arrival_time),
		.final_vehicle(final_vehicle),
		.cmd          (cmd),
		.cmd_valid    (cmd_valid),
		.cmd_take     (cmd_take)
	);

	hgg_engine #(
		.MAX_VEHICLES(MAX_VEHICLES),
		.TIME_BITS   (TIME_BITS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.cmd_valid(cmd_valid),
		.cmd_take (cmd_take),
		.res      (res),
		.res_push (res_push),
		.res_full (res_full)
	);

	hgg_result_fifo u_result_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.res_push(res_push),
		.res     (res),
		.res_full(res_full),
		.empty   (empty),
		.pop     (pop),
		.head    (res_head)
	);

	assign group_start = res_head.start;
	assign group_end   = res_head.stop;
	assign last_group  = res_head.last;

endmodule

// ----- sv/hgg_front.sv -----
// Front end: takes input requests, tags them as load or close, and queues them.
module hgg_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [hgg_pkg::IN_TIME_W-1:0] arrival_time,
	input  logic                      final_vehicle,
	output hgg_pkg::cmd_t             cmd,
	output logic                      cmd_valid,
	input  logic                      cmd_take
);
	import hgg_pkg::*;

	localparam int PW = $clog2(CMD_DEPTH);

	cmd_t           queue_q [CMD_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [PW:0]    fill_q;
	cmd_t           entry;
	logic           wr_en;
	logic           rd_en;

	assign full      = (fill_q == (PW+1)'(CMD_DEPTH));
	assign cmd_valid = (fill_q != '0);
	assign wr_en     = push && !full;
	assign rd_en     = cmd_take && cmd_valid;
	assign cmd       = queue_q[rd_ptr_q];

	always_comb begin
		entry.arrival = arrival_time;
		entry.op      = final_vehicle ? OP_CLOSE : OP_LOAD;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			queue_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (wr_en && !rd_en) begin
				fill_q <= fill_q + (PW+1)'(1);
			end else if (rd_en && !wr_en) begin
				fill_q <= fill_q - (PW+1)'(1);
			end
		end
	end

endmodule

// ----- sv/hgg_result_fifo.sv -----
// Result queue between the grouping engine and the result ports.
module hgg_result_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_push,
	input  hgg_pkg::res_t res,
	output logic          res_full,
	output logic          empty,
	input  logic          pop,
	output hgg_pkg::res_t head
);
	import hgg_pkg::*;

	localparam int PW = $clog2(RES_DEPTH);

	res_t           queue_q [RES_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [PW:0]    fill_q;
	logic           wr_en;
	logic           rd_en;

	assign res_full = (fill_q == (PW+1)'(RES_DEPTH));
	assign empty    = (fill_q == '0);
	assign wr_en    = res_push && !res_full;
	assign rd_en    = pop && !empty;
	assign head     = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			queue_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (wr_en && !rd_en) begin
				fill_q <= fill_q + (PW+1)'(1);
			end else if (rd_en && !wr_en) begin
				fill_q <= fill_q - (PW+1)'(1);
			end
		end
	end

endmodule

// ----- sv/hgg_engine.sv -----
// Back end: time store, threshold search over gap-counting passes, and group output.
module hgg_engine #(
	parameter int MAX_VEHICLES = 64,
	parameter int TIME_BITS    = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  hgg_pkg::cfg_t cfg,
	input  hgg_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_take,
	output hgg_pkg::res_t res,
	output logic          res_push,
	input  logic          res_full
);
	import hgg_pkg::*;

	localparam int IW    = $clog2(MAX_VEHICLES);
	localparam int CW    = $clog2(MAX_VEHICLES + 1);
	localparam int BW    = $clog2(TIME_BITS);
	localparam int SUM_W = TIME_BITS + STEP_W + 1;
	localparam int KW    = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam int XW    = (TIME_BITS > INIT_W) ? TIME_BITS : INIT_W;
	localparam logic [TIME_BITS-1:0] TMAX = '1;
	localparam logic [CW-1:0]        MAXC = CW'(MAX_VEHICLES);

	typedef enum logic [2:0] {
		S_LOAD,
		S_PASS,
		S_READ,
		S_EVAL,
		S_DECIDE,
		S_TRY,
		S_HEAD
	} state_t;

	typedef enum logic [1:0] {
		PH_BASE,
		PH_SEARCH,
		PH_OUTPUT
	} phase_t;

	logic [TIME_BITS-1:0] time_store_q [MAX_VEHICLES];
	logic [TIME_BITS-1:0] rdata_q;

	state_t               state_q;
	phase_t               phase_q;
	logic [CW-1:0]        count_q;
	logic [IW-1:0]        idx_q;
	logic                 prime_q;
	logic [CW-1:0]        breaks_q;
	logic [IW-1:0]        head_q;
	logic [BW-1:0]        bit_q;
	logic [TIME_BITS-1:0] acc_q;
	logic [TIME_BITS-1:0] try_q;
	logic [TIME_BITS-1:0] prev_q;

	logic [LIMIT_W-1:0]   limit_eff;
	logic [STEP_W-1:0]    step_eff;
	logic [XW-1:0]        init_wide;
	logic [TIME_BITS-1:0] init_clamp;
	logic [SUM_W-1:0]     try_sum;
	logic [TIME_BITS-1:0] try_sat;
	logic                 brk;
	logic                 last_elem;
	logic                 pass_ok;
	logic                 has_room;

	assign limit_eff  = (cfg.limit == '0) ? LIMIT_W'(1) : cfg.limit;
	assign step_eff   = (cfg.step == '0) ? STEP_W'(1) : cfg.step;
	assign init_wide  = XW'(cfg.init);
	assign init_clamp = (init_wide > XW'(TMAX)) ? TMAX : TIME_BITS'(init_wide);

	// Candidate threshold: accumulated threshold plus step scaled by the current search bit.
	assign try_sum = SUM_W'(acc_q) + (SUM_W'(step_eff) << bit_q);
	assign try_sat = (try_sum > SUM_W'(TMAX)) ? TMAX : TIME_BITS'(try_sum);

	assign brk       = (rdata_q > prev_q) && ((rdata_q - prev_q) > try_q);
	assign last_elem = (CW'(idx_q) == (count_q - CW'(1)));
	assign pass_ok   = (KW'(breaks_q) < KW'(limit_eff));
	assign has_room  = (count_q < MAXC);
	assign cmd_take  = (state_q == S_LOAD) && cmd_valid;

	always_ff @(posedge clk) begin
		if (cmd_take && has_room) begin
			time_store_q[count_q[IW-1:0]] <= TIME_BITS'(cmd.arrival);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			rdata_q <= time_store_q[idx_q];
		end
	end

	always_comb begin
		res_push = 1'b0;
		res      = '0;
		case (state_q)
			S_HEAD: begin
				res_push = 1'b1;
			end
			S_EVAL: begin
				if ((phase_q == PH_OUTPUT) && !prime_q && brk) begin
					res_push  = 1'b1;
					res.start = IDX_OUT_W'(head_q);
					res.stop  = IDX_OUT_W'(idx_q - IW'(1));
				end
			end
			S_DECIDE: begin
				if (phase_q == PH_OUTPUT) begin
					res_push  = 1'b1;
					res.start = IDX_OUT_W'(head_q);
					res.stop  = IDX_OUT_W'(count_q - CW'(1));
					res.last  = 1'b1;
				end
			end
			default: begin
				res_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			phase_q  <= PH_BASE;
			count_q  <= '0;
			idx_q    <= '0;
			prime_q  <= 1'b0;
			breaks_q <= '0;
			head_q   <= IW'(1);
			bit_q    <= '0;
			acc_q    <= '0;
			try_q    <= '0;
			prev_q   <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (cmd_valid) begin
						if (has_room) begin
							count_q <= count_q + CW'(1);
						end
						if (cmd.op == OP_CLOSE) begin
							try_q   <= init_clamp;
							phase_q <= PH_BASE;
							state_q <= S_PASS;
						end
					end
				end
				S_PASS: begin
					breaks_q <= '0;
					if (count_q < CW'(3)) begin
						state_q <= S_DECIDE;
					end else begin
						idx_q   <= IW'(1);
						prime_q <= 1'b1;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (prime_q) begin
						prev_q  <= rdata_q;
						prime_q <= 1'b0;
						idx_q   <= idx_q + IW'(1);
						state_q <= S_READ;
					end else if (!((phase_q == PH_OUTPUT) && brk && res_full)) begin
						breaks_q <= breaks_q + CW'(brk);
						if (brk) begin
							head_q <= idx_q;
						end
						prev_q <= rdata_q;
						if (last_elem) begin
							state_q <= S_DECIDE;
						end else begin
							idx_q   <= idx_q + IW'(1);
							state_q <= S_READ;
						end
					end
				end
				S_DECIDE: begin
					case (phase_q)
						PH_BASE: begin
							if (pass_ok) begin
								phase_q <= PH_OUTPUT;
								state_q <= S_HEAD;
							end else begin
								acc_q   <= try_q;
								bit_q   <= BW'(TIME_BITS - 1);
								phase_q <= PH_SEARCH;
								state_q <= S_TRY;
							end
						end
						PH_SEARCH: begin
							// A failing candidate becomes the new lower bound of the search.
							if (!pass_ok) begin
								acc_q <= try_q;
							end
							if (bit_q == '0) begin
								phase_q <= PH_OUTPUT;
							end else begin
								bit_q <= bit_q - BW'(1);
							end
							state_q <= S_TRY;
						end
						PH_OUTPUT: begin
							if (!res_full) begin
								count_q <= '0;
								state_q <= S_LOAD;
							end
						end
						default: begin
							state_q <= S_LOAD;
						end
					endcase
				end
				S_TRY: begin
					// With bit zero on entry to the output phase, this is the final threshold.
					try_q <= try_sat;
					if (phase_q == PH_OUTPUT) begin
						state_q <= S_HEAD;
					end else begin
						state_q <= S_PASS;
					end
				end
				S_HEAD: begin
					if (!res_full) begin
						head_q  <= IW'(1);
						state_q <= S_PASS;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

// ----- sv/hgg_checker.sv -----
// Port-level checker of the headway gap grouping core and its bind.
`include "headway_gap_grouping_core_macros.svh"

module hgg_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          empty,
	input logic                          pop,
	input logic [hgg_pkg::IDX_OUT_W-1:0] group_start,
	input logic [hgg_pkg::IDX_OUT_W-1:0] group_end,
	input logic                          last_group,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [hgg_pkg::ADDR_W-1:0]    paddr,
	input logic [hgg_pkg::DATA_W-1:0]    pwdata,
	input logic [hgg_pkg::DATA_W-1:0]    prdata,
	input logic                          pready
);
	import hgg_pkg::*;

	// A waiting result that is not taken stays in place.
	`HGG_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(group_start) && $stable(group_end) && $stable(last_group), "result changed while not taken")

	`HGG_ASSERT_IMPLY(a_pready, psel, pready, "configuration port not ready")

	// A group limit write reads back on the next cycle at the same address.
	`HGG_ASSERT_IMPLY(a_limit_rb, psel && penable && pwrite && paddr[3:2] == REG_LIMIT ##1 paddr[3:2] == REG_LIMIT, prdata[5:0] == $past(pwdata[5:0]), "group limit read-back mismatch")

	`HGG_ASSERT_IMPLY(a_limit_hi, paddr[3:2] == REG_LIMIT, prdata[31:6] == 26'd0, "group limit read has upper bits set")

endmodule

bind headway_gap_grouping_core hgg_checker u_hgg_checker (.*);

// ----- dv/tb_headway_gap_grouping_core.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the headway gap grouping core.
module tb_headway_gap_grouping_core;
	import hgg_pkg::*;

	localparam int STORE_DEPTH    = 64;
	localparam int STALL_LIMIT    = 20000;
	localparam int HOLDOFF_CYCLES = 600;

	typedef struct packed {
		logic [IN_TIME_W-1:0] arrival;
		op_t                  op;
	} vehicle_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 push          = 1'b0;
	logic [IN_TIME_W-1:0] arrival_time  = '0;
	logic                 final_vehicle = 1'b0;
	logic                 pop           = 1'b0;
	logic                 psel          = 1'b0;
	logic                 penable       = 1'b0;
	logic                 pwrite        = 1'b0;
	logic [ADDR_W-1:0]    paddr         = '0;
	logic [DATA_W-1:0]    pwdata        = '0;
	logic                 full;
	logic                 empty;
	logic [IDX_OUT_W-1:0] group_start;
	logic [IDX_OUT_W-1:0] group_end;
	logic                 last_group;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;

	// Shadow of the block's state and registers.
	logic [IN_TIME_W-1:0] stored_times [STORE_DEPTH];
	int                   stored_count = 0;
	cfg_t                 model_cfg    = '{limit: LIMIT_RST, init: INIT_RST, step: STEP_RST};

	vehicle_t arrival_queue [$];
	res_t     group_pairs [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit holdoff_go    = 1'b0;
	bit hold_rx       = 1'b0;
	bit arrival_taken = 1'b0;

	int error_count       = 0;
	int requests_accepted = 0;
	int sets_closed       = 0;
	int pairs_checked     = 0;
	int raised_runs       = 0;
	int saturated_runs    = 0;
	int full_stall_cycles = 0;
	int quiet_cycles      = 0;

	headway_gap_grouping_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.arrival_time (arrival_time),
		.final_vehicle(final_vehicle),
		.empty        (empty),
		.pop          (pop),
		.group_start  (group_start),
		.group_end    (group_end),
		.last_group   (last_group),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [IN_TIME_W-1:0] gap_before(int i);
		return (stored_times[i] > stored_times[i-1]) ? stored_times[i] - stored_times[i-1] : '0;
	endfunction

	// Gaps from element 2 on that open a new group at the given threshold.
	function automatic int count_breaks(int n, logic [IN_TIME_W-1:0] thr);
		int c;
		c = 0;
		for (int i = 2; i < n; i++)
			if (gap_before(i) > thr)
				c++;
		return c;
	endfunction

	function automatic void predict_groups(vehicle_t v);
		int                   n;
		int                   lim;
		int                   head;
		logic [63:0]          need;
		logic [63:0]          passes;
		logic [63:0]          room;
		logic [63:0]          stp;
		logic [63:0]          init_thr;
		logic [IN_TIME_W-1:0] thr;
		logic [IN_TIME_W-1:0] g;
		res_t                 pair;
		if (stored_count < STORE_DEPTH) begin
			stored_times[stored_count] = v.arrival;
			stored_count++;
		end
		if (v.op != OP_CLOSE)
			return;
		n = stored_count;
		lim = (model_cfg.limit == 0) ? 1 : int'(model_cfg.limit);
		stp = (model_cfg.step == 0) ? 64'd1 : 64'(model_cfg.step);
		init_thr = 64'(model_cfg.init);

		// Smallest gap threshold that keeps the group count within the limit.
		need = '0;
		if (count_breaks(n, '0) > lim - 1) begin
			need = 64'hFFFF_FFFF;
			for (int i = 2; i < n; i++) begin
				g = gap_before(i);
				if (g < need && count_breaks(n, g) <= lim - 1)
					need = 64'(g);
			end
		end

		// The block only reaches thresholds of the form initial + k * step, saturating.
		if (init_thr >= need) begin
			thr = init_thr[IN_TIME_W-1:0];
		end else begin
			passes = (need - init_thr - 1) / stp + 1;
			room = 64'hFFFF_FFFF - init_thr;
			raised_runs++;
			if (passes > room / stp) begin
				thr = '1;
				saturated_runs++;
			end else begin
				thr = IN_TIME_W'(init_thr + passes * stp);
			end
		end

		pair = '0;
		group_pairs.insert(group_pairs.size(), pair);
		head = 1;
		for (int i = 2; i < n; i++) begin
			if (gap_before(i) > thr) begin
				pair.start = IDX_OUT_W'(head);
				pair.stop = IDX_OUT_W'(i - 1);
				pair.last = 1'b0;
				group_pairs.insert(group_pairs.size(), pair);
				head = i;
			end
		end
		pair.start = IDX_OUT_W'(head);
		pair.stop = IDX_OUT_W'(n - 1);
		pair.last = 1'b1;
		group_pairs.insert(group_pairs.size(), pair);
		stored_count = 0;
		sets_closed++;
	endfunction

	always @(negedge clk) begin : drive_arrivals
		vehicle_t nxt;
		if (push && !arrival_taken) begin
			// The offered request has not been taken yet; keep it steady.
		end else if (arrival_queue.size() == 0 || $urandom_range(1, 100) <= send_idle_pct) begin
			push <= 1'b0;
		end else begin
			nxt = arrival_queue.pop_front();
			push <= 1'b1;
			arrival_time <= nxt.arrival;
			final_vehicle <= (nxt.op == OP_CLOSE);
		end
	end

	always @(negedge clk) begin
		pop <= !hold_rx && ($urandom_range(1, 100) > recv_idle_pct);
	end

	always @(posedge clk) begin : check_ports
		vehicle_t seen;
		res_t     want;
		if (arst_n) begin
			arrival_taken = push && !full;
			if (push && full)
				full_stall_cycles++;
			if (arrival_taken) begin
				seen.arrival = arrival_time;
				seen.op = final_vehicle ? OP_CLOSE : OP_LOAD;
				predict_groups(seen);
				requests_accepted++;
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_LIMIT: model_cfg.limit = pwdata[LIMIT_W-1:0];
					REG_INIT:  model_cfg.init = pwdata[INIT_W-1:0];
					REG_STEP:  model_cfg.step = pwdata[STEP_W-1:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (group_pairs.size() == 0) begin
					$display("%0t: unexpected pair start=%0d end=%0d last=%0b", $time,
						group_start, group_end, last_group);
					error_count++;
				end else begin
					want = group_pairs.pop_front();
					pairs_checked++;
					if (group_start !== want.start || group_end !== want.stop
						|| last_group !== want.last) begin
						$display("%0t: pair mismatch expected %0d/%0d/%0b actual %0d/%0d/%0b",
							$time, want.start, want.stop, want.last,
							group_start, group_end, last_group);
						error_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (psel && penable && pready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin : receiver_holdoff
		wait (holdoff_go);
		hold_rx = 1'b1;
		repeat (HOLDOFF_CYCLES) @(posedge clk);
		hold_rx = 1'b0;
	end

	task automatic set_register(input logic [1:0] idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] readback;
		logic [DATA_W-1:0] stored;
		case (idx)
			REG_LIMIT: stored = value & ((1 << LIMIT_W) - 1);
			REG_INIT:  stored = value;
			default:   stored = value & ((1 << STEP_W) - 1);
		endcase
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		readback = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback !== stored) begin
			$display("%0t: register %0d readback expected %0h actual %0h", $time, idx,
				stored, readback);
			error_count++;
		end
	endtask

	task automatic configure(input logic [LIMIT_W-1:0] lim_val, input logic [INIT_W-1:0] init_val,
		input logic [STEP_W-1:0] step_val);
		set_register(REG_LIMIT, DATA_W'(lim_val));
		set_register(REG_INIT, DATA_W'(init_val));
		set_register(REG_STEP, DATA_W'(step_val));
	endtask

	task automatic queue_item(input logic [IN_TIME_W-1:0] t, input op_t op);
		vehicle_t v;
		v.arrival = t;
		v.op = op;
		arrival_queue.insert(arrival_queue.size(), v);
	endtask

	// Mostly rising times with random gaps; now and then a repeat or a drop.
	task automatic queue_set(input int size, input logic [IN_TIME_W-1:0] span);
		logic [IN_TIME_W-1:0] t;
		t = $urandom >> $urandom_range(0, 31);
		for (int k = 0; k < size; k++) begin
			if (k > 0) begin
				case ($urandom_range(0, 15))
					0: t = t - $urandom_range(0, span);
					1: ;
					default: t = t + $urandom_range(0, span);
				endcase
			end
			queue_item(t, (k == size - 1) ? OP_CLOSE : OP_LOAD);
		end
	endtask

	// Waits until every request has been taken and every pair has come back.
	task automatic drain();
		while (arrival_queue.size() != 0 || push || group_pairs.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic run_phase(input int budget, input logic [IN_TIME_W-1:0] span);
		int queued;
		int size;
		queued = 0;
		while (queued < budget) begin
			size = ($urandom_range(0, 11) == 0) ? $urandom_range(30, STORE_DEPTH)
				: $urandom_range(1, 12);
			if (size > budget - queued)
				size = budget - queued;
			queue_set(size, span);
			queued += size;
		end
		drain();
	endtask

	initial begin : stimulus
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 38;
		recv_idle_pct = 59;

		// A lone vehicle, then a two-vehicle set that spans the whole time range.
		queue_item(32'hFFFF_FFFF, OP_CLOSE);
		queue_item(32'h0000_0000, OP_LOAD);
		queue_item(32'hFFFF_FFFF, OP_CLOSE);
		// Falling and repeated times never open a group.
		queue_item(32'd1000, OP_LOAD);
		queue_item(32'd5000, OP_LOAD);
		queue_item(32'd100, OP_LOAD);
		queue_item(32'd100, OP_LOAD);
		queue_item(32'd700, OP_LOAD);
		queue_item(32'd700, OP_CLOSE);
		// Gaps equal to the reset threshold stay in the group, one more splits it.
		queue_item(32'd0, OP_LOAD);
		queue_item(32'd0, OP_LOAD);
		queue_item(32'd256, OP_LOAD);
		queue_item(32'd512, OP_LOAD);
		queue_item(32'd769, OP_LOAD);
		queue_item(32'd769, OP_CLOSE);
		drain();

		// Zero limit and zero step behave as one.
		configure(6'd0, 32'd0, 16'd0);
		queue_item(32'd10, OP_LOAD);
		queue_item(32'd20, OP_LOAD);
		queue_item(32'd25, OP_LOAD);
		queue_item(32'd40, OP_LOAD);
		queue_item(32'd41, OP_CLOSE);
		drain();

		// A full-range gap pushes the threshold into saturation.
		configure(6'd1, 32'hFFFF_FF00, 16'hFFFF);
		queue_item(32'h0000_0000, OP_LOAD);
		queue_item(32'h0000_0000, OP_LOAD);
		queue_item(32'hFFFF_FFFF, OP_LOAD);
		queue_item(32'h0000_0000, OP_CLOSE);
		drain();

		configure(LIMIT_W'($urandom_range(1, 4)), INIT_W'($urandom_range(0, 512)),
			STEP_W'($urandom_range(1, 100)));
		run_phase(40, 600);

		send_idle_pct = 59;
		recv_idle_pct = 38;
		// More vehicles than the store holds; the extra times are dropped.
		configure(6'd63, 32'd1, 16'd1);
		queue_set(67, 64);
		run_phase(18, 64);

		configure(6'd62, INIT_W'($urandom), STEP_W'($urandom_range(0, 65535)));
		run_phase(40, 32'hFFFF_FFFF);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure(6'd2, 32'd0, 16'hFFFF);
		holdoff_go = 1'b1;
		run_phase(40, 300000);

		configure(LIMIT_W'($urandom_range(1, 8)), INIT_W'($urandom_range(0, 2000)),
			STEP_W'($urandom_range(1, 500)));
		run_phase(40, 3000);

		$display("Loaded %0d arrival requests in %0d vehicle sets; %0d group pairs checked.",
			requests_accepted, sets_closed, pairs_checked);
		$display("%0d runs raised the threshold, %0d saturated it; input held off %0d cycles.",
			raised_runs, saturated_runs, full_stall_cycles);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+sv
sv/hgg_pkg.sv
sv/hgg_front.sv
sv/hgg_result_fifo.sv
sv/hgg_engine.sv
sv/headway_gap_grouping_core.sv
sv/hgg_checker.sv
dv/tb_headway_gap_grouping_core.sv
